/* src/cls_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cls_pkg
// Shared widths, constants, codes and control types of the calibrated level
// sensor.
// ----------------------------------------------------------------------------
package cls_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int FRAC_BITS   = 16;

	localparam int CMD_W     = 2;
	localparam int CAL_H_W   = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int HEIGHT_W  = 12;
	localparam int DIST_W    = 13;
	localparam int SCALE_W   = 32;

	localparam int SUM_W  = SAMPLE_BITS + 2;
	localparam int PROD_W = SCALE_W + SAMPLE_BITS + 1;
	localparam int ACC_W  = PROD_W + 1;
	localparam int OFF_W  = PROD_W + 1;
	localparam int DQ_W   = PROD_W + 1;
	localparam int NUM_W  = ((FRAC_BITS + 9 > SAMPLE_BITS) ? FRAC_BITS + 9 : SAMPLE_BITS) + 1;
	localparam int DEN_W  = SAMPLE_BITS + 1;
	localparam int SQ_W   = (NUM_W + 1 > SCALE_W + 1) ? NUM_W + 1 : SCALE_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam int HALF         = 1 << (FRAC_BITS - 1);
	localparam int HEIGHT_MAX   = 4095;
	localparam int DIST_MAX     = 510;
	localparam int DIST_MIN_MAG = 4095;

	localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_ONE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET_TWO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_USF_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_USF_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0]       USF_OFFSET_RST = 8'd50;
	localparam logic [CFG_W-1:0]       USF_HEIGHT_RST = 8'd100;
	localparam logic [SCALE_W-1:0]     SCALE_RST      = 32'd7251;
	localparam logic [SCALE_W-1:0]     OFFSET_RST     = 32'd297009;
	localparam logic [SAMPLE_BITS-1:0] PT1_CODE_RST   = SAMPLE_BITS'(41);
	localparam logic [CAL_H_W-1:0]     PT1_H_RST      = 8'd0;
	localparam logic [SAMPLE_BITS-1:0] PT2_CODE_RST   = SAMPLE_BITS'(963);
	localparam logic [CAL_H_W-1:0]     PT2_H_RST      = 8'd100;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CHECK,
		S_DIV,
		S_SCALE,
		S_OMUL,
		S_OFFSET,
		S_HMUL,
		S_HADD,
		S_DIFF,
		S_ROUND
	} state_t;

	typedef struct packed {
		logic load;
		logic store;
		logic check;
		logic div_step;
		logic scale_ld;
		logic omul;
		logic off_ld;
		logic hmul;
		logic hadd;
		logic diff;
		logic out_ld;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cal;
		logic dx_zero;
	} dp_status_t;

endpackage
`default_nettype wire

/* src/cls_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cls_ctrl
// Sequencer of the level sensor: steps the datapath through averaging,
// calibration, division, scaling and rounding, and owns both handshakes.
// ----------------------------------------------------------------------------
module cls_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire cls_pkg::dp_status_t status,
	output cls_pkg::ctrl_cmd_t    cmd
);

	cls_pkg::state_t state_q, state_d;
	logic [cls_pkg::DIV_CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic slot_free;
	logic div_last;

	assign slot_free = !out_valid_q || out_ready;
	assign div_last  = (cnt_q == cls_pkg::DIV_CNT_W'(cls_pkg::NUM_W - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cls_pkg::S_IDLE:   if (in_valid) state_d = cls_pkg::S_DECODE;
			cls_pkg::S_DECODE: state_d = status.cal ? cls_pkg::S_CHECK : cls_pkg::S_HMUL;
			cls_pkg::S_CHECK:  state_d = status.dx_zero ? cls_pkg::S_HMUL : cls_pkg::S_DIV;
			cls_pkg::S_DIV:    if (div_last) state_d = cls_pkg::S_SCALE;
			cls_pkg::S_SCALE:  state_d = cls_pkg::S_OMUL;
			cls_pkg::S_OMUL:   state_d = cls_pkg::S_OFFSET;
			cls_pkg::S_OFFSET: state_d = cls_pkg::S_HMUL;
			cls_pkg::S_HMUL:   state_d = cls_pkg::S_HADD;
			cls_pkg::S_HADD:   state_d = cls_pkg::S_DIFF;
			cls_pkg::S_DIFF:   state_d = cls_pkg::S_ROUND;
			cls_pkg::S_ROUND:  if (slot_free) state_d = cls_pkg::S_IDLE;
			default:           state_d = cls_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cls_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			cls_pkg::S_DECODE: cmd.store    = status.cal;
			cls_pkg::S_CHECK:  cmd.check    = 1'b1;
			cls_pkg::S_DIV:    cmd.div_step = 1'b1;
			cls_pkg::S_SCALE:  cmd.scale_ld = 1'b1;
			cls_pkg::S_OMUL:   cmd.omul     = 1'b1;
			cls_pkg::S_OFFSET: cmd.off_ld   = 1'b1;
			cls_pkg::S_HMUL:   cmd.hmul     = 1'b1;
			cls_pkg::S_HADD:   cmd.hadd     = 1'b1;
			cls_pkg::S_DIFF:   cmd.diff     = 1'b1;
			cls_pkg::S_ROUND:  cmd.out_ld   = slot_free;
			default:           cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cls_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.check) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* src/cls_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cls_dp
// Datapath of the level sensor: sample average, calibration points, serial
// restoring divider for the slope, shared multiplier, offset, rounding and
// output registers.
// ----------------------------------------------------------------------------
module cls_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cls_pkg::ctrl_cmd_t                  cmd,
	output cls_pkg::dp_status_t                      status,
	input  wire logic                                cfg_we,
	input  wire logic [cls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cls_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic [cls_pkg::CMD_W-1:0]           command,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_a,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_b,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_c,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_d,
	input  wire logic [cls_pkg::CAL_H_W-1:0]         cal_height_cm,
	output logic [cls_pkg::HEIGHT_W-1:0]             height_cm,
	output logic signed [cls_pkg::DIST_W-1:0]        distance_cm,
	output logic                                     cal_status
);

	localparam int SB = cls_pkg::SAMPLE_BITS;
	localparam int FB = cls_pkg::FRAC_BITS;
	localparam int HW = cls_pkg::CAL_H_W;
	localparam int SW = cls_pkg::SCALE_W;
	localparam int HR_W = cls_pkg::PROD_W + 1 - FB;
	localparam int DR_W = cls_pkg::DQ_W - FB;

	logic [cls_pkg::CFG_W-1:0]  usf_off_q, usf_hgt_q;
	logic [SB-1:0]              pt1_code_q, pt2_code_q;
	logic [HW-1:0]              pt1_h_q, pt2_h_q;
	logic signed [SW-1:0]       scale_q, offset_q;

	logic [cls_pkg::CMD_W-1:0]  cmd_q;
	logic [SB-1:0]              avg_q;
	logic [HW-1:0]              calh_q;
	logic                       stat_q;
	logic [cls_pkg::DEN_W-1:0]  rem_q, den_q;
	logic [cls_pkg::NUM_W-1:0]  quo_q;
	logic                       neg_q;
	logic signed [cls_pkg::PROD_W-1:0] prod_q;
	logic [cls_pkg::PROD_W-1:0] hq_q;
	logic [cls_pkg::HEIGHT_W-1:0] h_q;
	logic signed [cls_pkg::DQ_W-1:0] dq_q;

	logic [cls_pkg::SUM_W-1:0]  sum;
	logic signed [HW:0]         dh, dh_abs;
	logic signed [SB:0]         dx, dx_abs;
	logic [cls_pkg::NUM_W-1:0]  num;
	logic [cls_pkg::DEN_W-1:0]  den;
	logic [cls_pkg::DEN_W:0]    trial, trial_sub;
	logic                       ge;
	logic signed [cls_pkg::SQ_W-1:0]  s_ext;
	logic [cls_pkg::SQ_W-SW:0]        s_top;
	logic signed [SW-1:0]             scale_sat;
	logic [SB-1:0]                    mul_x;
	logic signed [cls_pkg::PROD_W-1:0] prod_d;
	logic signed [cls_pkg::OFF_W-1:0]  off_full;
	logic [cls_pkg::OFF_W-SW:0]        off_top;
	logic signed [SW-1:0]              off_sat;
	logic signed [cls_pkg::ACC_W-1:0]  hsum;
	logic [cls_pkg::PROD_W:0]          hr;
	logic [HR_W-1:0]                   hr_int;
	logic [cls_pkg::HEIGHT_W-1:0]      h_d;
	logic [cls_pkg::CFG_W:0]           usf_sum;
	logic signed [cls_pkg::DQ_W-1:0]   dq_d;
	logic [cls_pkg::DQ_W-1:0]          dq_mag, dr;
	logic [DR_W-1:0]                   dr_int;
	logic signed [cls_pkg::DIST_W-1:0] dist_d;
	logic                              is_cal;

	assign sum = cls_pkg::SUM_W'(sample_a) + cls_pkg::SUM_W'(sample_b)
		+ cls_pkg::SUM_W'(sample_c) + cls_pkg::SUM_W'(sample_d);

	assign is_cal = (cmd_q == cls_pkg::CMD_SET_ONE) || (cmd_q == cls_pkg::CMD_SET_TWO);

	assign dh     = $signed({1'b0, pt2_h_q}) - $signed({1'b0, pt1_h_q});
	assign dx     = $signed({1'b0, pt2_code_q}) - $signed({1'b0, pt1_code_q});
	assign dh_abs = dh[HW] ? -dh : dh;
	assign dx_abs = dx[SB] ? -dx : dx;
	assign num    = cls_pkg::NUM_W'({dh_abs[HW-1:0], {FB{1'b0}}, 1'b0})
		+ cls_pkg::NUM_W'(dx_abs[SB-1:0]);
	assign den    = {dx_abs[SB-1:0], 1'b0};

	assign status.cal     = is_cal;
	assign status.dx_zero = (dx == '0);

	// One quotient bit per step of the restoring divider.
	assign trial     = {rem_q, quo_q[cls_pkg::NUM_W-1]};
	assign ge        = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	assign s_ext     = neg_q ? -$signed(cls_pkg::SQ_W'(quo_q)) : $signed(cls_pkg::SQ_W'(quo_q));
	assign s_top     = s_ext[cls_pkg::SQ_W-1:SW-1];
	assign scale_sat = ((&s_top) || !(|s_top)) ? s_ext[SW-1:0]
		: (s_ext[cls_pkg::SQ_W-1] ? $signed({1'b1, {(SW-1){1'b0}}})
		: $signed({1'b0, {(SW-1){1'b1}}}));

	assign mul_x  = cmd.omul ? pt1_code_q : avg_q;
	assign prod_d = cls_pkg::PROD_W'(scale_q) * cls_pkg::PROD_W'($signed({1'b0, mul_x}));

	assign off_full = $signed(cls_pkg::OFF_W'({pt1_h_q, {FB{1'b0}}}))
		- cls_pkg::OFF_W'(prod_q);
	assign off_top  = off_full[cls_pkg::OFF_W-1:SW-1];
	assign off_sat  = ((&off_top) || !(|off_top)) ? off_full[SW-1:0]
		: (off_full[cls_pkg::OFF_W-1] ? $signed({1'b1, {(SW-1){1'b0}}})
		: $signed({1'b0, {(SW-1){1'b1}}}));

	assign hsum = cls_pkg::ACC_W'(prod_q) + cls_pkg::ACC_W'(offset_q);

	assign hr     = (cls_pkg::PROD_W + 1)'(hq_q) + (cls_pkg::PROD_W + 1)'(cls_pkg::HALF);
	assign hr_int = hr[cls_pkg::PROD_W:FB];
	assign h_d    = (hr_int > HR_W'(cls_pkg::HEIGHT_MAX))
		? cls_pkg::HEIGHT_W'(cls_pkg::HEIGHT_MAX) : hr_int[cls_pkg::HEIGHT_W-1:0];

	assign usf_sum = {1'b0, usf_off_q} + {1'b0, usf_hgt_q};
	assign dq_d    = $signed(cls_pkg::DQ_W'({usf_sum, {FB{1'b0}}}))
		- $signed(cls_pkg::DQ_W'(hq_q));

	assign dq_mag = dq_q[cls_pkg::DQ_W-1] ? cls_pkg::DQ_W'(-dq_q) : cls_pkg::DQ_W'(dq_q);
	assign dr     = dq_mag + cls_pkg::DQ_W'(cls_pkg::HALF);
	assign dr_int = dr[cls_pkg::DQ_W-1:FB];

	always_comb begin
		if (dq_q[cls_pkg::DQ_W-1]) begin
			if (dr_int > DR_W'(cls_pkg::DIST_MIN_MAG)) begin
				dist_d = cls_pkg::DIST_W'(0) - cls_pkg::DIST_W'(cls_pkg::DIST_MIN_MAG);
			end else begin
				dist_d = cls_pkg::DIST_W'(0) - dr_int[cls_pkg::DIST_W-1:0];
			end
		end else begin
			if (dr_int > DR_W'(cls_pkg::DIST_MAX)) begin
				dist_d = cls_pkg::DIST_W'(cls_pkg::DIST_MAX);
			end else begin
				dist_d = $signed(dr_int[cls_pkg::DIST_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usf_off_q  <= cls_pkg::USF_OFFSET_RST;
			usf_hgt_q  <= cls_pkg::USF_HEIGHT_RST;
			scale_q    <= cls_pkg::SCALE_RST;
			offset_q   <= cls_pkg::OFFSET_RST;
			pt1_code_q <= cls_pkg::PT1_CODE_RST;
			pt1_h_q    <= cls_pkg::PT1_H_RST;
			pt2_code_q <= cls_pkg::PT2_CODE_RST;
			pt2_h_q    <= cls_pkg::PT2_H_RST;
		end else begin
			if (cfg_we && (cfg_index == cls_pkg::REG_USF_OFFSET)) begin
				usf_off_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_index == cls_pkg::REG_USF_HEIGHT)) begin
				usf_hgt_q <= cfg_wdata;
			end
			if (cmd.store) begin
				if (cmd_q == cls_pkg::CMD_SET_ONE) begin
					pt1_code_q <= avg_q;
					pt1_h_q    <= calh_q;
				end else begin
					pt2_code_q <= avg_q;
					pt2_h_q    <= calh_q;
				end
			end
			if (cmd.scale_ld) begin
				scale_q <= scale_sat;
			end
			if (cmd.off_ld) begin
				offset_q <= off_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			avg_q  <= sum[cls_pkg::SUM_W-1:2];
			calh_q <= cal_height_cm;
			stat_q <= 1'b0;
		end
		if (cmd.check) begin
			stat_q <= status.dx_zero;
			rem_q  <= '0;
			quo_q  <= num;
			den_q  <= den;
			neg_q  <= dh[HW] != dx[SB];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[cls_pkg::DEN_W-1:0] : trial[cls_pkg::DEN_W-1:0];
			quo_q <= {quo_q[cls_pkg::NUM_W-2:0], ge};
		end
		if (cmd.omul || cmd.hmul) begin
			prod_q <= prod_d;
		end
		if (cmd.hadd) begin
			hq_q <= hsum[cls_pkg::ACC_W-1] ? '0 : hsum[cls_pkg::PROD_W-1:0];
		end
		if (cmd.diff) begin
			h_q  <= h_d;
			dq_q <= dq_d;
		end
		if (cmd.out_ld) begin
			height_cm   <= h_q;
			distance_cm <= dist_d;
			cal_status  <= stat_q;
		end
	end

endmodule
`default_nettype wire

/* src/calibrated_level_sensor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// calibrated_level_sensor
// Two-point calibrated water level sensor: averages four converter samples,
// maintains slope and offset from two calibration points, and reports height
// and an emulated ultrasound distance in centimeters.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    command, sample_a..d, cal_height_cm
//   output    out_valid / out_ready  height_cm, distance_cm, cal_status
//   config    cfg_we                 cfg_index, cfg_wdata
//
// A measurement passes through the decode, multiply, add, difference and round
// steps. A calibration first stores its point, runs the restoring divider that
// forms the slope one bit per cycle, then loads scale and offset; equal codes
// skip these. The next item is accepted in the cycle after the result loads.
// One item is in work at a time; the output register holds a result while
// the next item is accepted, and a stalled output holds only the final step.
// Reset restores the factory calibration and the register defaults at once.
// ----------------------------------------------------------------------------
module calibrated_level_sensor (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [cls_pkg::CMD_W-1:0]           command,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_a,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_b,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_c,
	input  wire logic [cls_pkg::SAMPLE_BITS-1:0]     sample_d,
	input  wire logic [cls_pkg::CAL_H_W-1:0]         cal_height_cm,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [cls_pkg::HEIGHT_W-1:0]             height_cm,
	output logic signed [cls_pkg::DIST_W-1:0]        distance_cm,
	output logic                                     cal_status,
	input  wire logic                                cfg_we,
	input  wire logic [cls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cls_pkg::CFG_W-1:0]           cfg_wdata
);

	cls_pkg::ctrl_cmd_t  cmd;
	cls_pkg::dp_status_t status;

	cls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cls_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.command       (command),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.sample_c      (sample_c),
		.sample_d      (sample_d),
		.cal_height_cm (cal_height_cm),
		.height_cm     (height_cm),
		.distance_cm   (distance_cm),
		.cal_status    (cal_status)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath step in a cycle");

	a_equal_codes_skip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check && status.dx_zero |=> cmd.hmul)
		else $error("equal calibration codes did not skip the divider");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !in_ready && !out_valid || !in_ready)
		else $error("input ready during division");

endmodule
`default_nettype wire

/* tb/cls_reading_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cls_reading_check
// Watches the input, output and register ports of the calibrated level
// sensor. Every accepted input transfer runs through a local model of the
// two-point calibration and the height and distance arithmetic, and the
// predicted reading is queued. Every output transfer is compared field by
// field with the oldest queued reading. Mismatches and unexpected results
// are counted and reported with the simulation time.
// ----------------------------------------------------------------------------
module cls_reading_check
	import cls_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [CMD_W-1:0]             command,
	input  wire logic [SAMPLE_BITS-1:0]       sample_a,
	input  wire logic [SAMPLE_BITS-1:0]       sample_b,
	input  wire logic [SAMPLE_BITS-1:0]       sample_c,
	input  wire logic [SAMPLE_BITS-1:0]       sample_d,
	input  wire logic [CAL_H_W-1:0]           cal_height_cm,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [HEIGHT_W-1:0]          height_cm,
	input  wire logic signed [DIST_W-1:0]     distance_cm,
	input  wire logic                         cal_status,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]             cfg_wdata,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic [DIST_W-1:0]   distance;
		logic                status;
	} reading_t;

	reading_t       readings_due [$];
	int             errors;
	logic [CFG_W-1:0] usf_offset;
	logic [CFG_W-1:0] usf_height;
	int             slope_q;
	int             intercept_q;
	int             pt_one_code;
	int             pt_one_height;
	int             pt_two_code;
	int             pt_two_height;

	function automatic int clamp_s32(input longint v);
		if (v > S32_MAX)
			return int'(S32_MAX);
		if (v < S32_MIN)
			return int'(S32_MIN);
		return int'(v);
	endfunction

	// Divides by 2^FRAC_BITS, rounding half away from zero.
	function automatic longint round_cm(input longint v);
		longint half;
		half = longint'(1) <<< (FRAC_BITS - 1);
		if (v >= 0)
			return (v + half) >>> FRAC_BITS;
		return -((-v + half) >>> FRAC_BITS);
	endfunction

	function automatic logic fit_line();
		longint rise;
		longint run;
		longint mag_rise;
		longint mag_run;
		longint quot;
		longint slope;
		rise = longint'(pt_two_height) - longint'(pt_one_height);
		run  = longint'(pt_two_code) - longint'(pt_one_code);
		if (run == 0)
			return 1'b0;
		mag_rise = (rise < 0 ? -rise : rise) <<< FRAC_BITS;
		mag_run  = run < 0 ? -run : run;
		quot     = (2 * mag_rise + mag_run) / (2 * mag_run);
		slope    = ((rise < 0) != (run < 0)) ? -quot : quot;
		slope_q  = clamp_s32(slope);
		intercept_q = clamp_s32((longint'(pt_one_height) <<< FRAC_BITS)
			- longint'(slope_q) * longint'(pt_one_code));
		return 1'b1;
	endfunction

	function automatic reading_t predict_reading(
		input logic [CMD_W-1:0]       cmd,
		input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b,
		input logic [SAMPLE_BITS-1:0] c,
		input logic [SAMPLE_BITS-1:0] d,
		input logic [CAL_H_W-1:0]     calh
	);
		longint   code;
		longint   hq;
		longint   dq;
		longint   h;
		longint   dist_cm;
		reading_t r;
		code = (longint'(a) + longint'(b) + longint'(c) + longint'(d)) >>> 2;
		r.status = 1'b0;
		if (cmd == CMD_SET_ONE) begin
			pt_one_code   = int'(code);
			pt_one_height = int'(calh);
			r.status      = !fit_line();
		end else if (cmd == CMD_SET_TWO) begin
			pt_two_code   = int'(code);
			pt_two_height = int'(calh);
			r.status      = !fit_line();
		end
		hq = longint'(slope_q) * code + longint'(intercept_q);
		if (hq < 0)
			hq = 0;
		h = round_cm(hq);
		if (h > HEIGHT_MAX)
			h = HEIGHT_MAX;
		dq = ((longint'(usf_offset) + longint'(usf_height)) <<< FRAC_BITS) - hq;
		dist_cm = round_cm(dq);
		if (dist_cm < -DIST_MIN_MAG)
			dist_cm = -DIST_MIN_MAG;
		if (dist_cm > DIST_MAX)
			dist_cm = DIST_MAX;
		r.height   = h[HEIGHT_W-1:0];
		r.distance = dist_cm[DIST_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t due;
		if (!arst_n) begin
			readings_due.delete();
			errors        = 0;
			usf_offset    = USF_OFFSET_RST;
			usf_height    = USF_HEIGHT_RST;
			slope_q       = int'(SCALE_RST);
			intercept_q   = int'(OFFSET_RST);
			pt_one_code   = int'(PT1_CODE_RST);
			pt_one_height = int'(PT1_H_RST);
			pt_two_code   = int'(PT2_CODE_RST);
			pt_two_height = int'(PT2_H_RST);
			fail_count   <= 0;
			pending      <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_USF_OFFSET: usf_offset = cfg_wdata;
					REG_USF_HEIGHT: usf_height = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, height %0d distance %0d status %0d",
						$time, height_cm, distance_cm, cal_status);
				end else begin
					due = readings_due.pop_front();
					if (height_cm !== due.height) begin
						errors++;
						$display("%0t: height_cm expected %0d actual %0d",
							$time, due.height, height_cm);
					end
					if (distance_cm !== due.distance) begin
						errors++;
						$display("%0t: distance_cm expected %0d actual %0d",
							$time, $signed(due.distance), distance_cm);
					end
					if (cal_status !== due.status) begin
						errors++;
						$display("%0t: cal_status expected %0d actual %0d",
							$time, due.status, cal_status);
					end
				end
			end
			if (in_valid && in_ready)
				readings_due.push_back(predict_reading(command, sample_a, sample_b,
					sample_c, sample_d, cal_height_cm));
			fail_count <= errors;
			pending    <= readings_due.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the calibrated level sensor. A short directed
// sequence covers sample extremes, unused command code, equal calibration
// codes, negative slopes, clamping at zero and saturation of height, distance
// and offset. Random phases follow, each with its own register setting, with
// bursty input traffic and an output side that stalls in varying patterns.
// The checker instance predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb;
	import cls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 244;
	localparam int LIMIT_NS      = 6_000_000;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [CMD_W-1:0]          command;
	logic [SAMPLE_BITS-1:0]    sample_a;
	logic [SAMPLE_BITS-1:0]    sample_b;
	logic [SAMPLE_BITS-1:0]    sample_c;
	logic [SAMPLE_BITS-1:0]    sample_d;
	logic [CAL_H_W-1:0]        cal_height_cm;
	logic                      out_valid;
	logic                      out_ready;
	logic [HEIGHT_W-1:0]       height_cm;
	logic signed [DIST_W-1:0]  distance_cm;
	logic                      cal_status;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_wdata;
	int                        fail_count;
	int                        pending;

	int code_one   = int'(PT1_CODE_RST);
	int code_two   = int'(PT2_CODE_RST);
	int ready_mode = 0;
	int ready_left = 0;

	calibrated_level_sensor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.sample_c      (sample_c),
		.sample_d      (sample_d),
		.cal_height_cm (cal_height_cm),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.height_cm     (height_cm),
		.distance_cm   (distance_cm),
		.cal_status    (cal_status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	cls_reading_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.sample_c      (sample_c),
		.sample_d      (sample_d),
		.cal_height_cm (cal_height_cm),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.height_cm     (height_cm),
		.distance_cm   (distance_cm),
		.cal_status    (cal_status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_left <= $urandom_range(20, 200);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ($urandom_range(0, 15) == 0) ? !out_ready : out_ready;
		endcase
	end

	task automatic send_reading(
		input logic [CMD_W-1:0]       cmd,
		input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b,
		input logic [SAMPLE_BITS-1:0] c,
		input logic [SAMPLE_BITS-1:0] d,
		input logic [CAL_H_W-1:0]     calh
	);
		int code;
		code = (int'(a) + int'(b) + int'(c) + int'(d)) >> 2;
		@(negedge clk);
		in_valid      <= 1'b1;
		command       <= cmd;
		sample_a      <= a;
		sample_b      <= b;
		sample_c      <= c;
		sample_d      <= d;
		cal_height_cm <= calh;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (cmd == CMD_SET_ONE)
			code_one = code;
		else if (cmd == CMD_SET_TWO)
			code_two = code;
	endtask

	task automatic send_level(input logic [CMD_W-1:0] cmd, input int code,
		input logic [CAL_H_W-1:0] calh);
		logic [SAMPLE_BITS-1:0] smp;
		smp = SAMPLE_BITS'(code);
		send_reading(cmd, smp, smp, smp, smp, calh);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (cycles - 1)
				@(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
		endcase
	endfunction

	task automatic send_random();
		logic [CMD_W-1:0]       cmd;
		logic [SAMPLE_BITS-1:0] smp [4];
		logic [CAL_H_W-1:0]     calh;
		int                     pick;
		pick = $urandom_range(0, 99);
		if (pick < 68)
			cmd = CMD_MEASURE;
		else if (pick < 83)
			cmd = CMD_SET_ONE;
		else if (pick < 97)
			cmd = CMD_SET_TWO;
		else
			cmd = CMD_SPARE;
		case ($urandom_range(0, 9))
			0: begin
				pick = (cmd == CMD_SET_ONE) ? code_two : code_one;
				foreach (smp[i])
					smp[i] = SAMPLE_BITS'(pick);
			end
			1: begin
				smp[0] = rand_sample();
				foreach (smp[i])
					smp[i] = smp[0];
			end
			2: begin
				foreach (smp[i])
					smp[i] = $urandom_range(0, 1) ? '1 : '0;
			end
			default: begin
				foreach (smp[i])
					smp[i] = rand_sample();
			end
		endcase
		case ($urandom_range(0, 9))
			0: calh = '0;
			1: calh = '1;
			default: calh = CAL_H_W'($urandom_range(0, (1 << CAL_H_W) - 1));
		endcase
		send_reading(cmd, smp[0], smp[1], smp[2], smp[3], calh);
	endtask

	task automatic run_directed();
		send_level(CMD_MEASURE, 0, 8'd0);
		send_level(CMD_MEASURE, 1023, 8'd255);
		send_reading(CMD_MEASURE, 10'd1023, 10'd1022, 10'd1, 10'd0, 8'd0);
		send_reading(CMD_MEASURE, 10'd3, 10'd0, 10'd0, 10'd0, 8'd128);
		send_level(CMD_SPARE, 512, 8'd77);
		// Same code as point two: the old line must survive.
		send_level(CMD_SET_ONE, code_two, 8'd0);
		send_level(CMD_MEASURE, 500, 8'd0);
		send_level(CMD_SET_ONE, 0, 8'd255);
		send_level(CMD_MEASURE, 1023, 8'd0);
		send_level(CMD_SET_TWO, 1, 8'd0);
		send_level(CMD_MEASURE, 1023, 8'd0);
		send_level(CMD_SET_ONE, 1023, 8'd0);
		send_level(CMD_MEASURE, 700, 8'd0);
		// Steep negative slope pushes the offset past the signed 32-bit range.
		send_level(CMD_SET_TWO, 1022, 8'd255);
		send_level(CMD_MEASURE, 0, 8'd0);
		send_level(CMD_MEASURE, 1023, 8'd0);
		send_level(CMD_SET_ONE, 0, 8'd0);
		send_level(CMD_SET_TWO, 1, 8'd255);
		send_level(CMD_MEASURE, 1023, 8'd0);
		send_level(CMD_SET_TWO, 1, 8'd255);
		send_level(CMD_SET_ONE, 41, 8'd0);
		send_level(CMD_SET_TWO, 963, 8'd100);
		send_level(CMD_MEASURE, 502, 8'd0);
	endtask

	initial begin
		logic [CFG_W-1:0] ofs;
		logic [CFG_W-1:0] hgt;
		int               sent;
		int               burst;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		command       = CMD_MEASURE;
		sample_a      = '0;
		sample_b      = '0;
		sample_c      = '0;
		sample_d      = '0;
		cal_height_cm = '0;
		out_ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_USF_OFFSET;
		cfg_wdata     = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ofs = '0; hgt = '0; end
				1: begin ofs = '1; hgt = '1; end
				2: begin ofs = '0; hgt = '1; end
				3: begin ofs = '1; hgt = '0; end
				4: begin ofs = USF_OFFSET_RST; hgt = USF_HEIGHT_RST; end
				default: begin
					ofs = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
					hgt = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
				end
			endcase
			write_reg(REG_USF_OFFSET, ofs);
			write_reg(REG_USF_HEIGHT, hgt);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 12);
				for (int i = 0; i < burst; i++)
					send_random();
				sent += burst;
				hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
			end
			drain();
		end

		repeat (60)
			@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("calibrated_level_sensor verification clean");
		else
			$display("calibrated_level_sensor verification failed");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("calibrated_level_sensor verification failed");
		$finish;
	end

endmodule
`default_nettype wire
